/* rtl/core/ies_pkg.sv */
// Package for the image error statistics block: widths, config register
// indexes and the control/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package ies_pkg;
    localparam int PIXEL_COUNT_LOG2 = 20;
    localparam int CNT_W  = PIXEL_COUNT_LOG2 + 1;
    localparam int SSE_W  = 36;
    localparam int MSE_W  = 24;
    localparam int RMSE_W = 12;
    // total*256 fits in 38+8 bits
    localparam int NUM_W  = 46;
    localparam int DEN_W  = CNT_W + 2;
    localparam int DIV_STEPS = NUM_W;
    localparam int SQRT_STEPS = MSE_W / 2;
    localparam logic [MSE_W-1:0] LIMIT_RESET = 24'd16646400;

    localparam logic [1:0] REG_RMSE_EN    = 2'd0;
    localparam logic [1:0] REG_RMSE_LIMIT = 2'd1;
    localparam logic [1:0] REG_PSNR_EN    = 2'd2;
    localparam logic [1:0] REG_PSNR_LIMIT = 2'd3;

    typedef struct packed {
        logic accum;     // add accepted pixel into statistics
        logic start;     // latch totals, begin divide
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic finish;    // load output register, clear stats
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
    } t_status;
endpackage

/* rtl/core/ies_datapath.sv */
// Datapath: accumulators, restoring divider, digit-by-digit square root,
// gate compare and output register. Depends on ies_pkg.
`timescale 1ns / 1ps
module ies_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ies_pkg::t_cmd        i_cmd,
    output ies_pkg::t_status     o_status,
    input  logic [7:0]           i_rf, i_gf, i_bf, i_rs, i_gs, i_bs,
    input  logic                 i_rmse_en,
    input  logic [23:0]          i_rmse_lim,
    input  logic                 i_psnr_en,
    input  logic [23:0]          i_psnr_lim,
    output logic [35:0]          o_sse_red, o_sse_green, o_sse_blue,
    output logic [23:0]          o_mse,
    output logic [11:0]          o_rmse,
    output logic [7:0]           o_max,
    output logic [20:0]          o_diff_cnt,
    output logic [20:0]          o_pix_cnt,
    output logic                 o_fail
);
    import ies_pkg::*;

    logic [SSE_W-1:0] r_sse [3];
    logic [7:0]       r_max;
    logic [CNT_W-1:0] r_dcnt, r_pcnt;

    logic [7:0]  w_ad [3];
    logic [15:0] w_sq [3];
    logic [7:0]  w_a [3];
    logic [7:0]  w_b [3];
    assign w_a[0] = i_rf; assign w_a[1] = i_gf; assign w_a[2] = i_bf;
    assign w_b[0] = i_rs; assign w_b[1] = i_gs; assign w_b[2] = i_bs;

    logic [7:0] w_m01, w_max;
    logic       w_below;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_ad[c] = (w_a[c] >= w_b[c]) ? w_a[c] - w_b[c] : w_b[c] - w_a[c];
            w_sq[c] = {8'd0, w_ad[c]} * {8'd0, w_ad[c]};
        end
        w_m01 = (w_ad[0] > w_ad[1]) ? w_ad[0] : w_ad[1];
        w_max = (w_m01 > w_ad[2]) ? w_m01 : w_ad[2];
        if (r_max > w_max) w_max = r_max;
        w_below = ~r_pcnt[CNT_W-1];
    end

    // divider: restoring, one quotient bit per cycle
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   r_rem;
    logic [5:0]       r_dcount;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W+1:0] w_sub;
    always_comb begin
        w_trial = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
        w_sub   = {1'b0, w_trial} - {2'b00, r_den};
    end

    // square root on the quotient
    logic [MSE_W-1:0]  r_sq_v;
    logic [RMSE_W-1:0] r_root;
    logic [RMSE_W+1:0] r_srem;
    logic [3:0]        r_scount;
    logic [RMSE_W+1:0] w_st;
    logic [RMSE_W+2:0] w_ss;
    always_comb begin
        w_st = {r_srem[RMSE_W-1:0], r_sq_v[MSE_W-1 -: 2]};
        w_ss = {1'b0, w_st} - {1'b0, r_root, 2'b01};
    end

    logic [SSE_W+1:0] w_total;
    assign w_total = {2'b00, r_sse[0]} + {2'b00, r_sse[1]} + {2'b00, r_sse[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) r_sse[c] <= '0;
            r_max <= '0; r_dcnt <= '0; r_pcnt <= '0;
            r_dcount <= '0; r_scount <= '0;
        end else begin
            if (i_cmd.accum && w_below) begin
                for (int c = 0; c < 3; c++)
                    r_sse[c] <= r_sse[c] + SSE_W'(w_sq[c]);
                r_max  <= w_max;
                r_pcnt <= r_pcnt + 1'b1;
                if (w_ad[0] != 0 || w_ad[1] != 0 || w_ad[2] != 0)
                    r_dcnt <= r_dcnt + 1'b1;
            end
            if (i_cmd.start) begin
                r_num    <= {w_total, 8'd0};
                r_den    <= {1'b0, r_pcnt, 1'b0} + {2'b00, r_pcnt};
                r_rem    <= '0;
                r_dcount <= 6'(DIV_STEPS);
            end
            if (i_cmd.div_step) begin
                if (!w_sub[DEN_W+1]) begin
                    r_rem <= w_sub[DEN_W:0];
                    r_num <= {r_num[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                end
                r_dcount <= r_dcount - 1'b1;
            end
            if (i_cmd.sqrt_init) begin
                r_sq_v   <= r_num[MSE_W-1:0];
                r_root   <= '0;
                r_srem   <= '0;
                r_scount <= 4'(SQRT_STEPS);
            end
            if (i_cmd.sqrt_step) begin
                r_sq_v <= {r_sq_v[MSE_W-3:0], 2'b00};
                if (!w_ss[RMSE_W+2]) begin
                    r_srem <= w_ss[RMSE_W+1:0];
                    r_root <= {r_root[RMSE_W-2:0], 1'b1};
                end else begin
                    r_srem <= w_st;
                    r_root <= {r_root[RMSE_W-2:0], 1'b0};
                end
                r_scount <= r_scount - 1'b1;
            end
            if (i_cmd.finish) begin
                for (int c = 0; c < 3; c++) r_sse[c] <= '0;
                r_max <= '0; r_dcnt <= '0; r_pcnt <= '0;
            end
        end
    end

    // quotient held in r_num low bits after the divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_sse_red   <= r_sse[0];
            o_sse_green <= r_sse[1];
            o_sse_blue  <= r_sse[2];
            o_mse       <= r_num[MSE_W-1:0];
            o_rmse      <= r_root;
            o_max       <= r_max;
            o_diff_cnt  <= r_dcnt;
            o_pix_cnt   <= r_pcnt;
            o_fail      <= (i_rmse_en && r_num[MSE_W-1:0] > i_rmse_lim)
                        || (i_psnr_en && r_num[MSE_W-1:0] > i_psnr_lim);
        end
    end

    assign o_status.div_done  = (r_dcount == 6'd1);
    assign o_status.sqrt_done = (r_scount == 4'd1);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt <= r_pcnt) else $error("differing count above pixel count");
    a_pcnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= (CNT_W'(1) << PIXEL_COUNT_LOG2)) else $error("pixel count past bound");
    a_div_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_dcount != 0) else $error("divide step with no count");
endmodule

/* rtl/core/ies_ctrl.sv */
// Controller: handshakes, sequence of accumulate, divide, root and output.
// Depends on ies_pkg.
`timescale 1ns / 1ps
module ies_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    output ies_pkg::t_cmd    o_cmd,
    input  ies_pkg::t_status i_status
);
    import ies_pkg::*;

    typedef enum logic [2:0] {S_ACC, S_START, S_DIV, S_SQI, S_SQRT, S_FIN} t_state;
    t_state r_state;
    logic   r_ovalid;

    logic w_acc, w_out_take;
    assign w_out_take = r_ovalid && !i_stall;
    assign o_stall = (r_state != S_ACC);
    assign w_acc   = i_valid && !o_stall;
    assign o_valid = r_ovalid;

    always_comb begin
        o_cmd = '0;
        o_cmd.accum     = w_acc;
        o_cmd.start     = (r_state == S_START);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.sqrt_init = (r_state == S_SQI);
        o_cmd.sqrt_step = (r_state == S_SQRT);
        o_cmd.finish    = (r_state == S_FIN) && (!r_ovalid || w_out_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_ACC;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out_take) r_ovalid <= 1'b0;
            case (r_state)
                S_ACC:   if (w_acc && i_last) r_state <= S_START;
                S_START: r_state <= S_DIV;
                S_DIV:   if (i_status.div_done) r_state <= S_SQI;
                S_SQI:   r_state <= S_SQRT;
                S_SQRT:  if (i_status.sqrt_done) r_state <= S_FIN;
                S_FIN:   if (o_cmd.finish) begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_ACC;
                end
                default: r_state <= S_ACC;
            endcase
        end
    end

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> o_stall) else $error("input open during divide");
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_ovalid) else $error("result not shown after finish");
    a_last_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_last) |=> (r_state == S_START)) else $error("last item missed");
endmodule

/* rtl/core/image_error_statistics_top.sv */
// Image error statistics: one pixel pair per cycle is accumulated while the
// input is open. After the item marked last, the input stalls through start,
// the restoring divide, root init, the square root and output load, longer
// while the previous result still waits in the output register; then one
// result appears on the output register. Depends on ies_pkg.
`timescale 1ns / 1ps
module image_error_statistics_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red_first, i_green_first, i_blue_first,
    input  logic [7:0]  i_red_second, i_green_second, i_blue_second,
    input  logic        i_last_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [35:0] o_sse_red, o_sse_green, o_sse_blue,
    output logic [23:0] o_mse_overall_q8,
    output logic [11:0] o_rmse_overall_q4,
    output logic [7:0]  o_max_abs_diff,
    output logic [20:0] o_differing_pixels,
    output logic [20:0] o_pixels_seen,
    output logic        o_gate_failed,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import ies_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic        r_rmse_en, r_psnr_en;
    logic [23:0] r_rmse_lim, r_psnr_lim;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmse_en <= 1'b0; r_psnr_en <= 1'b0;
            r_rmse_lim <= LIMIT_RESET; r_psnr_lim <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RMSE_EN:    r_rmse_en  <= i_cfg_data[0];
                REG_RMSE_LIMIT: r_rmse_lim <= i_cfg_data;
                REG_PSNR_EN:    r_psnr_en  <= i_cfg_data[0];
                REG_PSNR_LIMIT: r_psnr_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ies_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_last(i_last_pixel), .o_stall,
        .o_valid, .i_stall, .o_cmd(w_cmd), .i_status(w_status)
    );

    ies_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_rf(i_red_first), .i_gf(i_green_first), .i_bf(i_blue_first),
        .i_rs(i_red_second), .i_gs(i_green_second), .i_bs(i_blue_second),
        .i_rmse_en(r_rmse_en), .i_rmse_lim(r_rmse_lim),
        .i_psnr_en(r_psnr_en), .i_psnr_lim(r_psnr_lim),
        .o_sse_red, .o_sse_green, .o_sse_blue,
        .o_mse(o_mse_overall_q8), .o_rmse(o_rmse_overall_q4), .o_max(o_max_abs_diff),
        .o_diff_cnt(o_differing_pixels), .o_pix_cnt(o_pixels_seen), .o_fail(o_gate_failed)
    );
endmodule

/* verif/tb_top.sv */
// Self-checking bench for image_error_statistics_top: streams pixel-pair images,
// predicts the per-image statistics and compares each result field by field.
// Depends on ies_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_top;
    import ies_pkg::*;

    typedef struct {
        logic [7:0] r1, g1, b1, r2, g2, b2;
        logic       last;
    } t_pix;

    typedef struct {
        logic [35:0] sse_r, sse_g, sse_b;
        logic [23:0] mse;
        logic [11:0] rmse;
        logic [7:0]  max_diff;
        logic [20:0] diff_cnt, pix_cnt;
        logic        fail;
    } t_stats;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_red_first = '0, i_green_first = '0, i_blue_first = '0;
    logic [7:0]  i_red_second = '0, i_green_second = '0, i_blue_second = '0;
    logic        i_last_pixel = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [35:0] o_sse_red, o_sse_green, o_sse_blue;
    logic [23:0] o_mse_overall_q8;
    logic [11:0] o_rmse_overall_q4;
    logic [7:0]  o_max_abs_diff;
    logic [20:0] o_differing_pixels, o_pixels_seen;
    logic        o_gate_failed;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    image_error_statistics_top DUT (.*);

    always #6 i_clk = ~i_clk;

    t_pix   pixel_q[$];
    t_stats stats_q[$];
    int     mismatches = 0;
    int     failures = 0;
    bit     steady = 0;      // no idling on either side
    bit     hold_req = 0;    // ask the receiver for one long hold-off
    int     hold_cnt = 0;

    // predictor state and register copy
    bit              rmse_en = 0, psnr_en = 0;
    logic [23:0]     rmse_lim = LIMIT_RESET, psnr_lim = LIMIT_RESET;
    longint unsigned acc_sse[3];
    longint unsigned acc_max, acc_diff, acc_pix;

    function automatic logic [11:0] root_of(logic [23:0] v);
        logic [11:0] r = '0;
        logic [11:0] t;
        for (int b = 11; b >= 0; b--) begin
            t = r | (12'd1 << b);
            if (32'(t) * 32'(t) <= 32'(v)) r = t;
        end
        return r;
    endfunction

    function automatic void absorb_pixel(t_pix p);
        longint unsigned a[3], b[3], d, tot, mse;
        bit differs = 0;
        t_stats s;
        a = '{p.r1, p.g1, p.b1};
        b = '{p.r2, p.g2, p.b2};
        if (acc_pix < (64'd1 << PIXEL_COUNT_LOG2)) begin
            for (int c = 0; c < 3; c++) begin
                d = a[c] >= b[c] ? a[c] - b[c] : b[c] - a[c];
                acc_sse[c] += d * d;
                if (d > acc_max) acc_max = d;
                if (d != 0) differs = 1;
            end
            if (differs) acc_diff++;
            acc_pix++;
        end
        if (!p.last) return;
        tot = acc_sse[0] + acc_sse[1] + acc_sse[2];
        mse = (tot << 8) / (3 * acc_pix);
        s.sse_r = 36'(acc_sse[0]);
        s.sse_g = 36'(acc_sse[1]);
        s.sse_b = 36'(acc_sse[2]);
        s.mse = 24'(mse);
        s.rmse = root_of(24'(mse));
        s.max_diff = 8'(acc_max);
        s.diff_cnt = 21'(acc_diff);
        s.pix_cnt = 21'(acc_pix);
        s.fail = (rmse_en && mse > rmse_lim) || (psnr_en && mse > psnr_lim);
        stats_q.push_back(s);
        acc_sse = '{0, 0, 0};
        acc_max = 0;
        acc_diff = 0;
        acc_pix = 0;
    endfunction

    // driver: predicts on acceptance, then offers the next item
    always @(posedge i_clk) begin
        t_pix p;
        if (i_valid && !o_stall)
            absorb_pixel('{i_red_first, i_green_first, i_blue_first, i_red_second,
                           i_green_second, i_blue_second, i_last_pixel});
        if (!i_valid || !o_stall) begin
            if (i_rst_n && pixel_q.size() > 0 && (steady || $urandom_range(99) >= 15)) begin
                p = pixel_q.pop_front();
                i_valid <= 1'b1;
                i_red_first <= p.r1;
                i_green_first <= p.g1;
                i_blue_first <= p.b1;
                i_red_second <= p.r2;
                i_green_second <= p.g2;
                i_blue_second <= p.b2;
                i_last_pixel <= p.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && hold_cnt == 0) begin
            hold_req <= 1'b0;
            hold_cnt <= 400;
            i_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall <= hold_cnt > 1;
        end else begin
            i_stall <= !steady && $urandom_range(99) < 15;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_stats e;
        if (o_valid && !i_stall) begin
            if (stats_q.size() == 0) begin
                failures++;
                if (mismatches++ < 10) $display("unexpected result at %0t", $realtime);
            end else begin
                e = stats_q.pop_front();
                if (e.sse_r !== o_sse_red || e.sse_g !== o_sse_green
                    || e.sse_b !== o_sse_blue || e.mse !== o_mse_overall_q8
                    || e.rmse !== o_rmse_overall_q4 || e.max_diff !== o_max_abs_diff
                    || e.diff_cnt !== o_differing_pixels || e.pix_cnt !== o_pixels_seen
                    || e.fail !== o_gate_failed) begin
                    failures++;
                    if (mismatches++ < 10)
                        $display({"mismatch: exp sse %0d %0d %0d mse %0d rmse %0d max %0d",
                                  " diff %0d pix %0d fail %0d / got sse %0d %0d %0d mse %0d",
                                  " rmse %0d max %0d diff %0d pix %0d fail %0d"},
                                 e.sse_r, e.sse_g, e.sse_b, e.mse, e.rmse, e.max_diff,
                                 e.diff_cnt, e.pix_cnt, e.fail, o_sse_red, o_sse_green,
                                 o_sse_blue, o_mse_overall_q8, o_rmse_overall_q4,
                                 o_max_abs_diff, o_differing_pixels, o_pixels_seen,
                                 o_gate_failed);
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_RMSE_EN:    rmse_en = val[0];
            REG_RMSE_LIMIT: rmse_lim = val;
            REG_PSNR_EN:    psnr_en = val[0];
            REG_PSNR_LIMIT: psnr_lim = val;
            default: ;
        endcase
    endtask

    task automatic set_gates(bit re, logic [23:0] rl, bit pe, logic [23:0] pl);
        write_reg(REG_RMSE_EN, {23'd0, re});
        write_reg(REG_RMSE_LIMIT, rl);
        write_reg(REG_PSNR_EN, {23'd0, pe});
        write_reg(REG_PSNR_LIMIT, pl);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pixel_q.size() > 0 || i_valid || stats_q.size() > 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic push_pixel(logic [7:0] r1, g1, b1, r2, g2, b2, logic last);
        pixel_q.push_back('{r1, g1, b1, r2, g2, b2, last});
    endtask

    // random image; near = small differences, else fully random bytes
    task automatic push_image(int len, bit near);
        logic [7:0] a[3], b[3];
        for (int n = 0; n < len; n++) begin
            foreach (a[c]) begin
                a[c] = 8'($urandom_range(255));
                b[c] = near ? 8'(a[c] + $urandom_range(6) - 3) : 8'($urandom_range(255));
                if ($urandom_range(9) == 0) b[c] = a[c];
            end
            push_pixel(a[0], a[1], a[2], b[0], b[1], b[2], n == len - 1);
        end
    endtask

    task automatic random_block(int images);
        repeat (images) push_image($urandom_range(3) == 0 ? 1 : int'($urandom_range(2, 24)),
                                   1'($urandom_range(1)));
    endtask

    initial begin
        acc_sse = '{0, 0, 0};
        acc_max = 0;
        acc_diff = 0;
        acc_pix = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset register values
        push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);        // identical
        push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);  // max error
        push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd170, 8'd85, 8'd7, 8'd170, 8'd85, 8'd7, 1'b0);
        push_pixel(8'd85, 8'd170, 8'd248, 8'd84, 8'd170, 8'd248, 1'b1);
        drain();
        // both gates on, limit zero: any error fails, identical passes
        set_gates(1, 24'd0, 1, 24'd0);
        push_pixel(8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 1'b1);
        push_pixel(8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd10, 1'b1);
        push_pixel(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b1);
        drain();
        // limits at the top: never exceeded, even at full error
        set_gates(1, LIMIT_RESET, 1, LIMIT_RESET);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
        push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
        // one below the full-error mse: strict compare
        drain();
        set_gates(0, LIMIT_RESET, 1, LIMIT_RESET - 1);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
        push_pixel(8'd254, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
        drain();
        set_gates(1, LIMIT_RESET - 1, 0, 24'd0);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
        push_pixel(8'd254, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
        drain();

        // random images over several gate settings
        for (int ph = 0; ph < 8; ph++) begin
            set_gates(1'($urandom_range(1)), 24'($urandom_range(LIMIT_RESET)),
                      1'($urandom_range(1)), 24'($urandom_range(2000000)));
            steady = (ph == 3);
            if (ph == 5) hold_req = 1'b1;
            random_block(18);
            drain();
        end
        steady = 0;

        set_gates(0, LIMIT_RESET, 0, LIMIT_RESET);
        random_block(10);
        drain();

        if (failures == 0 && stats_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(12ns * 400000);
        $display("simulation failed");
        $finish;
    end
endmodule
